[rtl/core/dnm_pkg.sv]
// Shared types and codes for the domain-to-node map table.
package dnm_pkg;

  // Width of slot indexes and stored node ids carried between cells; covers up to 256 slots
  localparam int SLOT_IDX_W = 8;

  // Request kinds
  localparam logic [1:0] KIND_SETUP    = 2'd0;
  localparam logic [1:0] KIND_DOM2NODE = 2'd1;
  localparam logic [1:0] KIND_NODE2DOM = 2'd2;
  localparam logic [1:0] KIND_CLEAR    = 2'd3;

  // Broadcast from the controller to every cell: held request plus update command
  typedef struct packed {
    logic [1:0]            kind;
    logic [31:0]           domain;
    logic [5:0]            node_in;
    logic                  wr_en;
    logic [SLOT_IDX_W-1:0] wr_idx;
    logic [SLOT_IDX_W-1:0] wr_node;
    logic                  clr;
  } cell_cmd_t;

  // Search record that walks the chain one cell per cycle
  typedef struct packed {
    logic                  vld;
    logic                  hit;
    logic [SLOT_IDX_W-1:0] hit_node;
    logic [31:0]           hit_domain;
    logic                  free_found;
    logic [SLOT_IDX_W-1:0] free_idx;
    logic                  direct_free;
  } scan_rec_t;

endpackage

[rtl/core/dnm_req_if.sv]
// Request channel of the domain-to-node map table.
interface dnm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] domain;
  logic [5:0]  node_in;

  modport source (output valid, output kind, output domain, output node_in, input ready);
  modport sink   (input valid, input kind, input domain, input node_in, output ready);
endinterface

[rtl/core/dnm_rsp_if.sv]
// Response channel of the domain-to-node map table.
interface dnm_rsp_if;
  logic        valid;
  logic        ready;
  logic [5:0]  node_out;
  logic [31:0] domain_out;
  logic        found;

  modport source (output valid, output node_out, output domain_out, output found, input ready);
  modport sink   (input valid, input node_out, input domain_out, input found, output ready);
endinterface

[rtl/core/dnm_cell.sv]
// One table slot: holds a mapping and updates the search record passing through.
module dnm_cell #(
  parameter int IDX    = 0,
  parameter int NODE_W = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  dnm_pkg::cell_cmd_t cmd,
  input  dnm_pkg::scan_rec_t rec_in,
  output dnm_pkg::scan_rec_t rec_out
);
  import dnm_pkg::*;

  logic              valid;
  logic [31:0]       dom;
  logic [NODE_W-1:0] node;
  scan_rec_t         rec_next;
  logic              match;
  logic              wr_here;

  assign wr_here = cmd.wr_en && (cmd.wr_idx == SLOT_IDX_W'(IDX));

  // Slot occupancy: clear drops every slot, a write claims this one
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.clr) begin
      valid <= 1'b0;
    end else if (wr_here) begin
      valid <= 1'b1;
    end
  end

  // Mapping payload
  always_ff @(posedge clk) begin
    if (wr_here) begin
      dom  <= cmd.domain;
      node <= NODE_W'(cmd.wr_node);
    end
  end

  // Compare against the held request; forward by node id for reverse lookups
  always_comb begin
    if (cmd.kind == KIND_NODE2DOM) begin
      match = valid && (SLOT_IDX_W'(node) == SLOT_IDX_W'(cmd.node_in));
    end else begin
      match = valid && (dom == cmd.domain);
    end
  end

  // Fold this slot into the record
  always_comb begin
    rec_next = rec_in;
    if (rec_in.vld) begin
      if (match && !rec_in.hit) begin
        rec_next.hit        = 1'b1;
        rec_next.hit_node   = SLOT_IDX_W'(node);
        rec_next.hit_domain = dom;
      end
      if (!valid && !rec_in.free_found) begin
        rec_next.free_found = 1'b1;
        rec_next.free_idx   = SLOT_IDX_W'(IDX);
      end
      if (!valid && (cmd.domain == 32'(IDX))) begin
        rec_next.direct_free = 1'b1;
      end
    end
  end

  // Hand the record to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_out <= '0;
    end else begin
      rec_out <= rec_next;
    end
  end

endmodule

[rtl/core/domain_to_node_map_table_core.sv]
// Top level of the domain-to-node map table: controller and chain of slot cells.
//
// Requests arrive on req (kind, domain, node_in) under valid/ready; one response per
// request leaves on rsp (node_out, domain_out, found) under valid/ready.
// Kinds: setup a domain, domain to node, node to domain, clear table.
// Each slot lives in its own cell. A search record enters cell 0 in the cycle after a
// request is taken and moves one cell per cycle, collecting the matching slot and the
// first free slot; the controller then decides and commits any update.
// One request is in work at a time: no new request is taken until the record has
// walked the whole chain and the controller has committed the result.
// The response sits in an output register; the next request is taken while it waits.
// If the receiver stalls with a response still held, a finished search holds until
// the register frees, and no new request is taken meanwhile.
// Reset empties every slot and zeroes the node counter; clear empties the slots but
// keeps the counter. Slot contents need no clearing pass after reset.
module domain_to_node_map_table_core #(
  parameter int SLOT_COUNT = 64
) (
  input logic     clk,
  input logic     rst,
  dnm_req_if.sink   req,
  dnm_rsp_if.source rsp
);
  import dnm_pkg::*;

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic             launch;
  logic [1:0]       req_kind;
  logic [31:0]      req_domain;
  logic [5:0]       req_node;
  logic [CNT_W-1:0] nodes_given;
  scan_rec_t        final_rec;

  logic             out_valid;
  logic [5:0]       out_node;
  logic [31:0]      out_domain;
  logic             out_found;

  scan_rec_t        rec [SLOT_COUNT+1];
  logic [SLOT_COUNT:0] rec_vld;
  cell_cmd_t        cell_cmd;

  logic             accept;
  logic             commit;
  logic             dec_wr;
  logic             dec_clr;
  logic [IDX_W-1:0] dec_idx;
  logic [5:0]       dec_node;
  logic [31:0]      dec_domain;
  logic             dec_found;
  logic             have_slot;
  logic [SLOT_IDX_W-1:0] given_ext;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign commit    = (state == ST_DONE) && (!out_valid || rsp.ready);

  assign rsp.valid      = out_valid;
  assign rsp.node_out   = out_node;
  assign rsp.domain_out = out_domain;
  assign rsp.found      = out_found;

  // Inject the record at the head of the chain
  assign rec[0] = '{vld: launch, default: '0};

  genvar g;
  generate
    for (g = 0; g < SLOT_COUNT; g++) begin : g_cell
      dnm_cell #(
        .IDX    (g),
        .NODE_W (IDX_W)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .cmd     (cell_cmd),
        .rec_in  (rec[g]),
        .rec_out (rec[g+1])
      );
    end
    for (g = 0; g <= SLOT_COUNT; g++) begin : g_vld
      assign rec_vld[g] = rec[g].vld;
    end
  endgenerate

  // Hold the request while it is in work
  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind   <= req.kind;
      req_domain <= req.domain;
      req_node   <= req.node_in;
    end
  end

  // Capture the record at the end of the chain
  always_ff @(posedge clk) begin
    if (rec[SLOT_COUNT].vld) begin
      final_rec <= rec[SLOT_COUNT];
    end
  end

  // Decide the response and the table update from the finished search
  always_comb begin
    given_ext  = SLOT_IDX_W'(nodes_given);
    have_slot  = final_rec.direct_free || final_rec.free_found;
    dec_idx    = final_rec.direct_free ? req_domain[IDX_W-1:0]
                                       : final_rec.free_idx[IDX_W-1:0];
    dec_wr     = 1'b0;
    dec_clr    = 1'b0;
    dec_node   = '0;
    dec_domain = '0;
    dec_found  = 1'b0;
    case (req_kind)
      KIND_SETUP: begin
        if (final_rec.hit) begin
          dec_node  = final_rec.hit_node[5:0];
          dec_found = 1'b1;
        end else if (have_slot && (nodes_given < CNT_W'(SLOT_COUNT))) begin
          dec_wr    = 1'b1;
          dec_node  = given_ext[5:0];
          dec_found = 1'b1;
        end
      end
      KIND_DOM2NODE: begin
        if (final_rec.hit) begin
          dec_node  = final_rec.hit_node[5:0];
          dec_found = 1'b1;
        end
      end
      KIND_NODE2DOM: begin
        if (final_rec.hit) begin
          dec_node   = req_node;
          dec_domain = final_rec.hit_domain;
          dec_found  = 1'b1;
        end
      end
      KIND_CLEAR: begin
        dec_clr = 1'b1;
      end
      default: begin
        dec_clr = 1'b0;
      end
    endcase
  end

  // Broadcast the held request and the commit to every cell
  always_comb begin
    cell_cmd         = '0;
    cell_cmd.kind    = req_kind;
    cell_cmd.domain  = req_domain;
    cell_cmd.node_in = req_node;
    cell_cmd.wr_en   = commit && dec_wr;
    cell_cmd.wr_idx  = SLOT_IDX_W'(dec_idx);
    cell_cmd.wr_node = given_ext;
    cell_cmd.clr     = commit && dec_clr;
  end

  // Sequence: take request, walk the chain, commit
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (rec[SLOT_COUNT].vld) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (commit) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      launch      <= 1'b0;
      nodes_given <= '0;
      out_valid   <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= accept;
      // Advance the node counter on a new mapping
      if (commit && dec_wr) begin
        nodes_given <= nodes_given + CNT_W'(1);
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (commit) begin
      out_node   <= dec_node;
      out_domain <= dec_domain;
      out_found  <= dec_found;
    end
  end

  // Only one search record is ever in the chain
  a_one_record: assert property (@(posedge clk) disable iff (rst)
    $countones(rec_vld) <= 1)
    else $error("more than one search record in the chain");

  // A record reaches the end of the chain only while scanning
  a_end_in_scan: assert property (@(posedge clk) disable iff (rst)
    rec[SLOT_COUNT].vld |-> (state == ST_SCAN))
    else $error("search record finished outside the scan state");

  // The node counter saturates at the slot count
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    nodes_given <= CNT_W'(SLOT_COUNT))
    else $error("node counter passed the slot count");

  // A commit always produces a response on the next cycle
  a_commit_rsp: assert property (@(posedge clk) disable iff (rst)
    commit |=> (out_valid && (state == ST_IDLE)))
    else $error("commit did not load the response");

endmodule
